// ===== design/mbrs_pkg.sv =====
`timescale 1ns / 1ps

package mbrs_pkg;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  rx_byte;
      logic        rx_last;
      logic [7:0]  host_index;
      logic [15:0] host_value;
   } mbrs_req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  out_byte;
      logic        out_last;
      logic [7:0]  done_function;
      logic [15:0] host_data;
   } mbrs_rsp_type;

   // request commands
   localparam logic [2:0] CMD_FRAME_BYTE = 3'd0;
   localparam logic [2:0] CMD_WRITE_IREG = 3'd1;
   localparam logic [2:0] CMD_SET_IBIT   = 3'd2;
   localparam logic [2:0] CMD_READ_HREG  = 3'd3;
   localparam logic [2:0] CMD_READ_COIL  = 3'd4;

   localparam logic OUT_KIND_FRAME = 1'b0;
   localparam logic OUT_KIND_HOST  = 1'b1;

   // function codes
   localparam logic [7:0] FN_READ_COILS    = 8'd1;
   localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FN_READ_INPUT    = 8'd4;
   localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FN_WRITE_REG     = 8'd6;
   localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FN_WRITE_REGS    = 8'd16;

   // exception codes
   localparam logic [1:0] EXC_NONE  = 2'd0;
   localparam logic [1:0] EXC_FUNC  = 2'd1;
   localparam logic [1:0] EXC_ADDR  = 2'd2;
   localparam logic [1:0] EXC_VALUE = 2'd3;

   localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
   localparam logic [7:0]  EXC_FLAG       = 8'h80;
   localparam logic [15:0] COIL_ON        = 16'hFF00;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam int         MIN_FRAME_BYTES   = 4;
   localparam int         MULTI_MIN_BYTES   = 7;
   localparam logic [9:0] FIXED_FRAME_BYTES = 10'd8;
   localparam logic [9:0] MULTI_HDR_BYTES   = 10'd9;
   localparam int         DATA_OFFSET       = 7;

   // register index, taken from paddr[2]
   localparam logic CSR_SLAVE_ADDR = 1'b0;

   typedef enum logic [4:0] {
      S_IDLE,
      S_HOST_RD,
      S_HOST_EMIT,
      S_FSTART,
      S_SCAN_RD,
      S_SCAN_USE,
      S_CHECK,
      S_EXEC,
      S_W15_RD,
      S_W15_USE,
      S_W16_RDH,
      S_W16_RDL,
      S_W16_WR,
      S_RESP,
      S_BITS,
      S_REG_RD,
      S_REG_HI,
      S_REG_LO,
      S_CRC_LO,
      S_CRC_HI,
      S_FEND
   } mbrs_state_type;

   // one byte through the reflected CRC-16
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/mbrs_regfile.sv =====
`timescale 1ns / 1ps

module mbrs_regfile #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [15:0]              wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [15:0]              rd_data
);

   logic [15:0]      entry_mem [DEPTH];
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [15:0]      q_ff;
   logic             q_vld_ff;

   // an entry never written reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) vld_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         q_ff     <= entry_mem[rd_addr];
         q_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = q_vld_ff ? q_ff : 16'h0000;

endmodule

// ===== design/modbus_rtu_slave_responder_unit.sv =====
`timescale 1ns / 1ps

// Modbus RTU slave. Frame bytes, input register writes and discrete input
// sets are taken and the block is ready again at once. A host read of a
// holding register passes a read and an emit state, a coil read only the emit
// state, and each emit waits on the result side. The byte flagged last starts
// frame work, during which no word is taken: a start state, a read and a use
// state per stored frame byte for the CRC pass through the single read port
// of the frame store and the one shared CRC unit, check and execute states,
// for writes a read and a use state per coil data byte (function 15) or two
// reads and a write per register (function 16), one emit per response byte, a
// read and two emits per register on register reads, and a close state. The
// four tables come up zero out of reset; no clearing pass is needed.
module modbus_rtu_slave_responder_unit
   import mbrs_pkg::*;
#(
   parameter int COIL_COUNT           = 256,
   parameter int INPUT_BIT_COUNT      = 256,
   parameter int HOLD_REG_COUNT       = 128,
   parameter int INPUT_REG_COUNT      = 128,
   parameter int MAX_REGS_PER_REQUEST = 29,
   parameter int FRAME_BYTES          = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mbrs_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mbrs_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int FLEN_W  = $clog2(FRAME_BYTES + 1);
   localparam int FIDX_W  = $clog2(FRAME_BYTES);
   localparam int HOLD_AW = $clog2(HOLD_REG_COUNT);
   localparam int IREG_AW = $clog2(INPUT_REG_COUNT);
   localparam int COIL_AW = $clog2(COIL_COUNT);
   localparam int IBIT_AW = $clog2(INPUT_BIT_COUNT);
   localparam logic [16:0] COIL_SZ  = 17'(COIL_COUNT);
   localparam logic [16:0] IBIT_SZ  = 17'(INPUT_BIT_COUNT);
   localparam logic [16:0] HOLD_SZ  = 17'(HOLD_REG_COUNT);
   localparam logic [16:0] IREG_SZ  = 17'(INPUT_REG_COUNT);
   localparam logic [16:0] MAX_REGS = 17'(MAX_REGS_PER_REQUEST);

   mbrs_state_type state_ff, state_in;
   logic [7:0]  slave_addr_ff;
   logic [FLEN_W-1:0] flen_ff, flen_in, count_ff, count_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in, crc_next, rxcrc_ff, rxcrc_in;
   logic [7:0]  addr_ff, addr_in, func_ff, func_in, bcnt_ff, bcnt_in, hi_ff, hi_in;
   logic [15:0] start_ff, start_in, qty_ff, qty_in, host_ff, host_in;
   logic [1:0]  err_ff, err_in, err_c;
   logic [7:0]  fq_ff;
   logic [COIL_COUNT-1:0]      coil_ff, coil_in;
   logic [INPUT_BIT_COUNT-1:0] ibit_ff, ibit_in;
   logic         rsp_valid_ff, rsp_valid_in;
   mbrs_rsp_type rsp_data_ff, emit_word;

   logic        crc_init, crc_en, emit, slot_free;
   logic [7:0]  crc_data;
   logic        fwr_en;
   logic [FIDX_W-1:0] frd_addr;
   logic        c5_en, w15_en, ib_en;
   logic        hw_en, hr_en, iw_en, ir_en;
   logic [HOLD_AW-1:0] hr_addr;
   logic [15:0] hw_data, hr_data, ir_data;
   logic [15:0] reg_idx;
   logic [16:0] start17, qty17, end17, bit_off, bit_base;
   logic [9:0]  need_c, k10, flen10;
   logic        is_multi, is_bits, is_regs, drop_c, bits_last, regs_last;
   logic [7:0]  hdr_byte, bits_byte, bytecount;
   logic [2:0]  hdr_last;
   logic [7:0]  fstore_mem [FRAME_BYTES];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign start17   = {1'b0, start_ff};
   assign qty17     = {1'b0, qty_ff};
   assign end17     = start17 + qty17;
   assign bit_off   = 17'(count_ff) << 3;
   assign bit_base  = start17 + bit_off;
   assign reg_idx   = start_ff + 16'(count_ff);
   assign k10       = 10'(count_ff);
   assign flen10    = 10'(flen_ff);
   assign is_multi  = (func_ff == FN_WRITE_COILS) || (func_ff == FN_WRITE_REGS);
   assign is_bits   = (func_ff == FN_READ_COILS) || (func_ff == FN_READ_DISCRETE);
   assign is_regs   = (func_ff == FN_READ_HOLDING) || (func_ff == FN_READ_INPUT);
   assign bits_last = (bit_off + 17'd8) >= qty17;
   assign regs_last = (17'(count_ff) + 17'd1) == qty17;
   assign crc_next  = crc_byte(crc_ff, crc_data);

   // frame store
   always_ff @(posedge clock) begin
      if (fwr_en) fstore_mem[flen_ff[FIDX_W-1:0]] <= req_data.rx_byte;
      fq_ff <= fstore_mem[frd_addr];
   end

   mbrs_regfile #(.DEPTH(HOLD_REG_COUNT)) u_hreg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hw_en),
      .wr_addr (reg_idx[HOLD_AW-1:0]),
      .wr_data (hw_data),
      .rd_en   (hr_en),
      .rd_addr (hr_addr),
      .rd_data (hr_data)
   );

   mbrs_regfile #(.DEPTH(INPUT_REG_COUNT)) u_ireg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (iw_en),
      .wr_addr (req_data.host_index[IREG_AW-1:0]),
      .wr_data (req_data.host_value),
      .rd_en   (ir_en),
      .rd_addr (reg_idx[IREG_AW-1:0]),
      .rd_data (ir_data)
   );

   // bytes needed for this function
   always_comb begin
      if (func_ff >= FN_READ_COILS && func_ff <= FN_WRITE_REG) begin
         need_c = FIXED_FRAME_BYTES;
      end else if (is_multi) begin
         need_c = MULTI_HDR_BYTES + 10'(bcnt_ff);
      end else begin
         need_c = flen10;
      end
   end

   assign drop_c = (addr_ff != slave_addr_ff && addr_ff != BROADCAST_ADDR)
                || (is_multi && flen_ff < FLEN_W'(MULTI_MIN_BYTES))
                || (need_c > flen10)
                || (crc_ff != rxcrc_ff);

   always_comb begin
      logic [16:0] size;
      err_c = EXC_NONE;
      size  = COIL_SZ;
      case (func_ff)
         FN_READ_COILS, FN_READ_DISCRETE: begin
            size = (func_ff == FN_READ_COILS) ? COIL_SZ : IBIT_SZ;
            if (start17 >= size) err_c = EXC_ADDR;
            else if (qty_ff == 16'h0000 || qty17 > size) err_c = EXC_VALUE;
            else if (end17 > size) err_c = EXC_ADDR;
         end
         FN_READ_HOLDING, FN_READ_INPUT: begin
            size = (func_ff == FN_READ_HOLDING) ? HOLD_SZ : IREG_SZ;
            if (start17 >= size) err_c = EXC_ADDR;
            else if (qty_ff == 16'h0000 || qty17 > MAX_REGS) err_c = EXC_VALUE;
            else if (end17 > size) err_c = EXC_ADDR;
         end
         FN_WRITE_COIL: begin
            if (start17 >= COIL_SZ) err_c = EXC_ADDR;
            else if (qty_ff != COIL_ON && qty_ff != 16'h0000) err_c = EXC_VALUE;
         end
         FN_WRITE_REG: begin
            if (start17 >= HOLD_SZ) err_c = EXC_ADDR;
         end
         FN_WRITE_COILS: begin
            if (start17 >= COIL_SZ) err_c = EXC_ADDR;
            else if (qty_ff == 16'h0000 || qty17 > COIL_SZ) err_c = EXC_VALUE;
            else if (end17 > COIL_SZ) err_c = EXC_ADDR;
            else if (17'(bcnt_ff) != ((qty17 + 17'd7) >> 3)) err_c = EXC_VALUE;
         end
         FN_WRITE_REGS: begin
            if (start17 >= HOLD_SZ) err_c = EXC_ADDR;
            else if (qty_ff == 16'h0000 || qty17 > MAX_REGS) err_c = EXC_VALUE;
            else if (end17 > HOLD_SZ) err_c = EXC_ADDR;
            else if (17'(bcnt_ff) != (qty17 << 1)) err_c = EXC_VALUE;
         end
         default: err_c = EXC_FUNC;
      endcase
   end

   // response header bytes
   assign bytecount = is_bits ? 8'((qty17 + 17'd7) >> 3) : 8'(qty17 << 1);
   assign hdr_last  = (err_ff != EXC_NONE || is_bits || is_regs) ? 3'd2 : 3'd5;

   always_comb begin
      case (pos_ff)
         3'd0: hdr_byte = addr_ff;
         3'd1: hdr_byte = (err_ff != EXC_NONE) ? (func_ff | EXC_FLAG) : func_ff;
         3'd2: begin
            if (err_ff != EXC_NONE) hdr_byte = {6'b0, err_ff};
            else if (is_bits || is_regs) hdr_byte = bytecount;
            else hdr_byte = start_ff[15:8];
         end
         3'd3: hdr_byte = start_ff[7:0];
         3'd4: hdr_byte = qty_ff[15:8];
         3'd5: hdr_byte = qty_ff[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   // eight table bits of a coil or discrete input data byte
   always_comb begin
      logic [16:0] bi;
      bits_byte = 8'h00;
      bi = '0;
      for (int b = 0; b < 8; b++) begin
         bi = bit_base + 17'(b);
         if (bit_off + 17'(b) < qty17) begin
            if (func_ff == FN_READ_COILS) begin
               bits_byte[b] = (bi < COIL_SZ) && coil_ff[bi[COIL_AW-1:0]];
            end else begin
               bits_byte[b] = (bi < IBIT_SZ) && ibit_ff[bi[IBIT_AW-1:0]];
            end
         end
      end
   end

   always_comb begin
      logic [16:0] ci;
      coil_in = coil_ff;
      ci = '0;
      if (c5_en) coil_in[start_ff[COIL_AW-1:0]] = (qty_ff == COIL_ON);
      if (w15_en) begin
         for (int i = 0; i < COIL_COUNT; i++) begin
            ci = 17'(i);
            if (ci >= bit_base && ci < bit_base + 17'd8 && ci - start17 < qty17) begin
               coil_in[i] = fq_ff[3'(ci - bit_base)];
            end
         end
      end
   end

   always_comb begin
      ibit_in = ibit_ff;
      if (ib_en) ibit_in[req_data.host_index[IBIT_AW-1:0]] = req_data.host_value[0];
   end

   always_comb begin
      state_in  = state_ff;
      flen_in   = flen_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      rxcrc_in  = rxcrc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      start_in  = start_ff;
      qty_in    = qty_ff;
      bcnt_in   = bcnt_ff;
      err_in    = err_ff;
      hi_in     = hi_ff;
      host_in   = host_ff;
      crc_init  = 1'b0;
      crc_en    = 1'b0;
      crc_data  = fq_ff;
      req_ready = 1'b0;
      fwr_en    = 1'b0;
      frd_addr  = count_ff[FIDX_W-1:0];
      c5_en     = 1'b0;
      w15_en    = 1'b0;
      ib_en     = 1'b0;
      hw_en     = 1'b0;
      hw_data   = {hi_ff, fq_ff};
      hr_en     = 1'b0;
      hr_addr   = reg_idx[HOLD_AW-1:0];
      iw_en     = 1'b0;
      ir_en     = 1'b0;
      emit      = 1'b0;
      emit_word = '0;
      emit_word.out_kind = OUT_KIND_FRAME;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.command)
                  CMD_FRAME_BYTE: begin
                     if (flen_ff < FLEN_W'(FRAME_BYTES)) begin
                        fwr_en  = 1'b1;
                        flen_in = flen_ff + 1'b1;
                     end
                     if (req_data.rx_last) state_in = S_FSTART;
                  end
                  CMD_WRITE_IREG: begin
                     iw_en = 9'(req_data.host_index) < 9'(INPUT_REG_COUNT);
                  end
                  CMD_SET_IBIT: begin
                     ib_en = 9'(req_data.host_index) < 9'(INPUT_BIT_COUNT);
                  end
                  CMD_READ_HREG: begin
                     if (9'(req_data.host_index) < 9'(HOLD_REG_COUNT)) begin
                        hr_en    = 1'b1;
                        hr_addr  = req_data.host_index[HOLD_AW-1:0];
                        state_in = S_HOST_RD;
                     end else begin
                        host_in  = 16'h0000;
                        state_in = S_HOST_EMIT;
                     end
                  end
                  CMD_READ_COIL: begin
                     host_in = {15'b0, (9'(req_data.host_index) < 9'(COIL_COUNT))
                                && coil_ff[req_data.host_index[COIL_AW-1:0]]};
                     state_in = S_HOST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         S_HOST_RD: begin
            host_in  = hr_data;
            state_in = S_HOST_EMIT;
         end
         S_HOST_EMIT: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_word.out_kind  = OUT_KIND_HOST;
               emit_word.host_data = host_ff;
               state_in = S_IDLE;
            end
         end
         S_FSTART: begin
            crc_init = 1'b1;
            count_in = '0;
            state_in = (flen_ff < FLEN_W'(MIN_FRAME_BYTES)) ? S_FEND : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_USE;
         end
         S_SCAN_USE: begin
            if (count_ff == FLEN_W'(0)) addr_in = fq_ff;
            if (count_ff == FLEN_W'(1)) func_in = fq_ff;
            if (count_ff == FLEN_W'(2)) start_in[15:8] = fq_ff;
            if (count_ff == FLEN_W'(3)) start_in[7:0] = fq_ff;
            if (count_ff == FLEN_W'(4)) qty_in[15:8] = fq_ff;
            if (count_ff == FLEN_W'(5)) qty_in[7:0] = fq_ff;
            if (count_ff == FLEN_W'(6)) bcnt_in = fq_ff;
            // function code is not known yet for the first two bytes
            if (count_ff < FLEN_W'(2) || k10 + 10'd2 < need_c) crc_en = 1'b1;
            if (k10 + 10'd2 == need_c) rxcrc_in[7:0] = fq_ff;
            if (k10 + 10'd1 == need_c) rxcrc_in[15:8] = fq_ff;
            if (count_ff + 1'b1 == flen_ff) begin
               state_in = S_CHECK;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_CHECK: begin
            if (drop_c) begin
               state_in = S_FEND;
            end else begin
               err_in   = err_c;
               crc_init = 1'b1;
               pos_in   = 3'd0;
               count_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (err_ff == EXC_NONE) begin
               case (func_ff)
                  FN_WRITE_COIL: c5_en = 1'b1;
                  FN_WRITE_REG: begin
                     hw_en   = 1'b1;
                     hw_data = qty_ff;
                  end
                  FN_WRITE_COILS: state_in = S_W15_RD;
                  FN_WRITE_REGS:  state_in = S_W16_RDH;
                  default: ;
               endcase
            end
         end
         S_W15_RD: begin
            frd_addr = FIDX_W'(count_ff + FLEN_W'(DATA_OFFSET));
            state_in = S_W15_USE;
         end
         S_W15_USE: begin
            w15_en = 1'b1;
            if (bits_last) begin
               count_in = '0;
               state_in = S_RESP;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_W15_RD;
            end
         end
         S_W16_RDH: begin
            frd_addr = FIDX_W'(((FLEN_W+1)'(count_ff) << 1) + (FLEN_W+1)'(DATA_OFFSET));
            state_in = S_W16_RDL;
         end
         S_W16_RDL: begin
            hi_in    = fq_ff;
            frd_addr = FIDX_W'(((FLEN_W+1)'(count_ff) << 1) + (FLEN_W+1)'(DATA_OFFSET + 1));
            state_in = S_W16_WR;
         end
         S_W16_WR: begin
            hw_en = 1'b1;
            if (regs_last) begin
               count_in = '0;
               state_in = S_RESP;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_W16_RDH;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               emit     = 1'b1;
               emit_word.out_byte = hdr_byte;
               crc_en   = 1'b1;
               crc_data = hdr_byte;
               pos_in   = pos_ff + 1'b1;
               if (pos_ff == hdr_last) begin
                  if (err_ff != EXC_NONE) state_in = S_CRC_LO;
                  else if (is_bits) state_in = S_BITS;
                  else if (is_regs) state_in = S_REG_RD;
                  else state_in = S_CRC_LO;
               end
            end
         end
         S_BITS: begin
            if (slot_free) begin
               emit     = 1'b1;
               emit_word.out_byte = bits_byte;
               crc_en   = 1'b1;
               crc_data = bits_byte;
               if (bits_last) begin
                  state_in = S_CRC_LO;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_REG_RD: begin
            hr_en    = (func_ff == FN_READ_HOLDING);
            ir_en    = (func_ff != FN_READ_HOLDING);
            state_in = S_REG_HI;
         end
         S_REG_HI: begin
            if (slot_free) begin
               emit     = 1'b1;
               crc_en   = 1'b1;
               crc_data = (func_ff == FN_READ_HOLDING) ? hr_data[15:8] : ir_data[15:8];
               emit_word.out_byte = crc_data;
               state_in = S_REG_LO;
            end
         end
         S_REG_LO: begin
            if (slot_free) begin
               emit     = 1'b1;
               crc_en   = 1'b1;
               crc_data = (func_ff == FN_READ_HOLDING) ? hr_data[7:0] : ir_data[7:0];
               emit_word.out_byte = crc_data;
               if (regs_last) begin
                  state_in = S_CRC_LO;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = S_REG_RD;
               end
            end
         end
         S_CRC_LO: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_word.out_byte = crc_ff[7:0];
               state_in = S_CRC_HI;
            end
         end
         S_CRC_HI: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_word.out_byte = crc_ff[15:8];
               emit_word.out_last = 1'b1;
               emit_word.done_function = (err_ff == EXC_NONE) ? func_ff : 8'h00;
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            flen_in  = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign crc_in       = crc_init ? CRC_INIT : (crc_en ? crc_next : crc_ff);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         slave_addr_ff <= 8'h01;
         coil_ff       <= '0;
         ibit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         flen_ff      <= flen_in;
         rsp_valid_ff <= rsp_valid_in;
         coil_ff      <= coil_in;
         ibit_ff      <= ibit_in;
         if (psel && penable && pwrite && pready && paddr[2] == CSR_SLAVE_ADDR) begin
            slave_addr_ff <= pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      pos_ff   <= pos_in;
      crc_ff   <= crc_in;
      rxcrc_ff <= rxcrc_in;
      addr_ff  <= addr_in;
      func_ff  <= func_in;
      start_ff <= start_in;
      qty_ff   <= qty_in;
      bcnt_ff  <= bcnt_in;
      err_ff   <= err_in;
      hi_ff    <= hi_in;
      host_ff  <= host_in;
      if (emit) rsp_data_ff <= emit_word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_SLAVE_ADDR) ? {24'h0, slave_addr_ff} : 32'h0;

   a_frame_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_FRAME_BYTE && req_data.rx_last
      |=> !req_ready)
      else $error("word accepted while frame work pending");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !emit)
      else $error("result word overwritten before taken");

   a_scan_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_USE |-> count_ff < flen_ff)
      else $error("scan past frame end");

   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FEND |=> flen_ff == '0 && req_ready)
      else $error("frame length not cleared after frame");

endmodule

// ===== verif/modbus_rtu_slave_responder_unit_chk.sv =====
`timescale 1ns / 1ps

package mbrs_tb_pkg;

   // advance a Modbus CRC-16 by one byte, low bit first
   function automatic logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ 16'hA001;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

module modbus_rtu_slave_responder_unit_chk
   import mbrs_pkg::*;
   import mbrs_tb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  mbrs_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  mbrs_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output int           fail_count,
   output int           pending,
   output int           frames_answered,
   output int           host_reads
);

   logic [7:0]   station;
   logic [7:0]   fstore[128];
   int           flen;
   logic         coil_bit[256];
   logic         dinput_bit[256];
   logic [15:0]  hold_reg[128];
   logic [15:0]  in_reg[128];
   mbrs_rsp_type reply_q[$];

   initial begin
      fail_count      = 0;
      pending         = 0;
      frames_answered = 0;
      host_reads      = 0;
   end

   task automatic push_reply(input logic kind, input logic [7:0] b, input logic last,
                             input logic [7:0] fn, input logic [15:0] data);
      mbrs_rsp_type r;
      r.out_kind      = kind;
      r.out_byte      = b;
      r.out_last      = last;
      r.done_function = fn;
      r.host_data     = data;
      reply_q.push_back(r);
   endtask

   // work out the response to the frame held in the store
   task automatic answer_frame();
      int          need, start, qty, n, nbytes;
      logic [7:0]  adr, fn, v;
      logic [1:0]  exc;
      logic [15:0] crc;
      logic [7:0]  rb[70];
      if (flen < 4) return;
      adr = fstore[0];
      if (adr != station && adr != BROADCAST_ADDR) return;
      fn = fstore[1];
      if (fn >= FN_READ_COILS && fn <= FN_WRITE_REG) begin
         need = 8;
      end else if (fn == FN_WRITE_COILS || fn == FN_WRITE_REGS) begin
         if (flen < 7) return;
         need = 9 + fstore[6];
      end else begin
         need = flen;
      end
      if (need > flen) return;
      crc = CRC_INIT;
      for (int i = 0; i < need - 2; i++) crc = crc_advance(crc, fstore[i]);
      if (crc != {fstore[need-1], fstore[need-2]}) return;

      rb[0] = adr;
      rb[1] = fn;
      n     = 2;
      exc   = EXC_NONE;
      start = {fstore[2], fstore[3]};
      qty   = {fstore[4], fstore[5]};
      case (fn)
         FN_READ_COILS, FN_READ_DISCRETE: begin
            if (start >= 256) exc = EXC_ADDR;
            else if (qty == 0 || qty > 256) exc = EXC_VALUE;
            else if (start + qty > 256) exc = EXC_ADDR;
            else begin
               nbytes = (qty + 7) / 8;
               rb[n++] = nbytes[7:0];
               for (int b = 0; b < nbytes; b++) begin
                  v = 8'h00;
                  for (int k = 0; k < 8; k++) begin
                     if (b * 8 + k < qty)
                        v[k] = (fn == FN_READ_COILS) ? coil_bit[start + b * 8 + k]
                                                     : dinput_bit[start + b * 8 + k];
                  end
                  rb[n++] = v;
               end
            end
         end
         FN_READ_HOLDING, FN_READ_INPUT: begin
            if (start >= 128) exc = EXC_ADDR;
            else if (qty == 0 || qty > 29) exc = EXC_VALUE;
            else if (start + qty > 128) exc = EXC_ADDR;
            else begin
               rb[n++] = 8'(qty * 2);
               for (int k = 0; k < qty; k++) begin
                  v = 8'h00;
                  if (fn == FN_READ_HOLDING) {rb[n], rb[n+1]} = hold_reg[start + k];
                  else {rb[n], rb[n+1]} = in_reg[start + k];
                  n += 2;
               end
            end
         end
         FN_WRITE_COIL: begin
            if (start >= 256) exc = EXC_ADDR;
            else if (qty == COIL_ON) coil_bit[start] = 1'b1;
            else if (qty == 0) coil_bit[start] = 1'b0;
            else exc = EXC_VALUE;
         end
         FN_WRITE_REG: begin
            if (start >= 128) exc = EXC_ADDR;
            else hold_reg[start] = qty[15:0];
         end
         FN_WRITE_COILS: begin
            if (start >= 256) exc = EXC_ADDR;
            else if (qty == 0 || qty > 256) exc = EXC_VALUE;
            else if (start + qty > 256) exc = EXC_ADDR;
            else if (fstore[6] != (qty + 7) / 8) exc = EXC_VALUE;
            else
               for (int k = 0; k < qty; k++) coil_bit[start + k] = fstore[7 + k / 8][k % 8];
         end
         FN_WRITE_REGS: begin
            if (start >= 128) exc = EXC_ADDR;
            else if (qty == 0 || qty > 29) exc = EXC_VALUE;
            else if (start + qty > 128) exc = EXC_ADDR;
            else if (fstore[6] != qty * 2) exc = EXC_VALUE;
            else
               for (int k = 0; k < qty; k++)
                  hold_reg[start + k] = {fstore[7 + 2 * k], fstore[8 + 2 * k]};
         end
         default: exc = EXC_FUNC;
      endcase

      if (exc != EXC_NONE) begin
         rb[1] = fn | EXC_FLAG;
         rb[2] = {6'b0, exc};
         n     = 3;
      end else if (fn >= FN_WRITE_COIL) begin
         for (int k = 2; k < 6; k++) rb[n++] = fstore[k];
      end
      crc = CRC_INIT;
      for (int i = 0; i < n; i++) crc = crc_advance(crc, rb[i]);
      rb[n++] = crc[7:0];
      rb[n++] = crc[15:8];
      for (int i = 0; i < n; i++)
         push_reply(OUT_KIND_FRAME, rb[i], i == n - 1,
                    (i == n - 1 && exc == EXC_NONE) ? fn : 8'h00, 16'h0000);
      frames_answered++;
   endtask

   task automatic predict_word(input mbrs_req_type w);
      case (w.command)
         CMD_FRAME_BYTE: begin
            if (flen < 128) fstore[flen++] = w.rx_byte;
            if (w.rx_last) begin
               answer_frame();
               flen = 0;
            end
         end
         CMD_WRITE_IREG: if (w.host_index < 128) in_reg[w.host_index] = w.host_value;
         CMD_SET_IBIT:   dinput_bit[w.host_index] = w.host_value[0];
         CMD_READ_HREG: begin
            push_reply(OUT_KIND_HOST, 8'h00, 1'b0, 8'h00,
                       (w.host_index < 128) ? hold_reg[w.host_index] : 16'h0000);
            host_reads++;
         end
         CMD_READ_COIL: begin
            push_reply(OUT_KIND_HOST, 8'h00, 1'b0, 8'h00, {15'b0, coil_bit[w.host_index]});
            host_reads++;
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input int e, input int a);
      if (e != a) begin
         $display("%0t: %s expected %0h got %0h", $time, name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      mbrs_rsp_type e;
      if (reset) begin
         station = 8'd1;
         flen    = 0;
         for (int i = 0; i < 256; i++) begin
            coil_bit[i]   = 1'b0;
            dinput_bit[i] = 1'b0;
         end
         for (int i = 0; i < 128; i++) begin
            hold_reg[i] = 16'h0000;
            in_reg[i]   = 16'h0000;
         end
         reply_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected word, expected none got %h", $time, rsp_data);
               fail_count++;
            end else begin
               e = reply_q.pop_front();
               compare_field("out_kind", e.out_kind, rsp_data.out_kind);
               compare_field("out_byte", e.out_byte, rsp_data.out_byte);
               compare_field("out_last", e.out_last, rsp_data.out_last);
               compare_field("done_function", e.done_function, rsp_data.done_function);
               compare_field("host_data", e.host_data, rsp_data.host_data);
            end
         end
         if (req_valid && req_ready) predict_word(req_data);
         if (psel && penable && pwrite && pready && paddr[2] == CSR_SLAVE_ADDR)
            station = pwdata[7:0];
      end
      pending = reply_q.size();
   end

endmodule

// ===== verif/modbus_rtu_slave_responder_unit_tb.sv =====
`timescale 1ns / 1ps

module modbus_rtu_slave_responder_unit_tb;
   import mbrs_pkg::*;
   import mbrs_tb_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   mbrs_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   mbrs_rsp_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   int           fail_count;
   int           pending;
   int           frames_answered;
   int           host_reads;
   int           words_sent;
   int           idle_cycles;
   int           hold_left;
   logic         calm;
   logic [7:0]   cur_station;
   logic [7:0]   frame_q[$];

   modbus_rtu_slave_responder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   modbus_rtu_slave_responder_unit_chk i_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .frames_answered(frames_answered),
      .host_reads     (host_reads)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("modbus_rtu_slave_responder_unit_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver stalls: mostly short, a few long
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            hold_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
         end
      end
   end

   task automatic send_word(input logic [2:0] cmd, input logic [7:0] b, input logic last,
                            input logic [7:0] idx, input logic [15:0] val);
      int gap;
      req_valid           <= 1'b1;
      req_data.command    <= cmd;
      req_data.rx_byte    <= b;
      req_data.rx_last    <= last;
      req_data.host_index <= idx;
      req_data.host_value <= val;
      do @(posedge clock); while (!req_ready);
      if (cmd <= CMD_READ_COIL) words_sent++;
      if (!calm) begin
         gap = $urandom_range(0, 99);
         gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_word(CMD_FRAME_BYTE, frame_q[i], i == frame_q.size() - 1,
                   8'($urandom), 16'($urandom));
   endtask

   task automatic put16(input logic [15:0] v);
      frame_q.push_back(v[15:8]);
      frame_q.push_back(v[7:0]);
   endtask

   // append the CRC, low byte first
   task automatic seal_frame();
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (frame_q[i]) crc = crc_advance(crc, frame_q[i]);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
   endtask

   task automatic request(input logic [7:0] adr, input logic [7:0] fn,
                          input logic [15:0] start, input logic [15:0] qty,
                          input int nbytes, input int bcount);
      frame_q.delete();
      frame_q.push_back(adr);
      frame_q.push_back(fn);
      put16(start);
      put16(qty);
      if (bcount >= 0) frame_q.push_back(8'(bcount));
      repeat (nbytes) frame_q.push_back(8'($urandom));
      seal_frame();
   endtask

   task automatic host_word();
      logic [2:0] cmd;
      cmd = 3'($urandom_range(1, 7));
      send_word(cmd, 8'($urandom), 1'($urandom),
                8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 127)),
                16'($urandom));
   endtask

   // mostly well-formed requests with random content, some broken ones
   task automatic random_frame();
      int         r, start, qty, bc, nbytes;
      logic [7:0] adr, fn;
      r   = $urandom_range(0, 99);
      adr = ($urandom_range(0, 9) == 0) ? BROADCAST_ADDR : cur_station;
      if (r >= 94) adr = cur_station + 8'($urandom_range(1, 254));
      if (r < 2) begin
         frame_q.delete();
         frame_q.push_back(adr);
         repeat ($urandom_range(129, 140)) frame_q.push_back(8'($urandom));
      end else if (r < 6) begin
         frame_q.delete();
         frame_q.push_back(adr);
         repeat ($urandom_range(0, 5)) frame_q.push_back(8'($urandom));
      end else if (r < 12) begin
         do fn = 8'($urandom); while ((fn >= FN_READ_COILS && fn <= FN_WRITE_REG) ||
                                      fn == FN_WRITE_COILS || fn == FN_WRITE_REGS);
         frame_q.delete();
         frame_q.push_back(adr);
         frame_q.push_back(fn);
         repeat ($urandom_range(0, 5)) frame_q.push_back(8'($urandom));
         seal_frame();
      end else begin
         bc     = -1;
         nbytes = 0;
         case ($urandom_range(0, 7))
            0: fn = FN_READ_COILS;
            1: fn = FN_READ_DISCRETE;
            2: fn = FN_READ_HOLDING;
            3: fn = FN_READ_INPUT;
            4: fn = FN_WRITE_COIL;
            5: fn = FN_WRITE_REG;
            6: fn = FN_WRITE_COILS;
            default: fn = FN_WRITE_REGS;
         endcase
         case (fn)
            FN_READ_COILS, FN_READ_DISCRETE, FN_WRITE_COILS: begin
               start = $urandom_range(0, 255);
               qty   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256 - start)
                                                   : $urandom_range(1, (256 - start) / 8 + 1);
            end
            FN_READ_HOLDING, FN_READ_INPUT, FN_WRITE_REGS: begin
               start = $urandom_range(0, 127);
               qty   = $urandom_range(1, (128 - start < 29) ? 128 - start : 29);
            end
            FN_WRITE_COIL: begin
               start = $urandom_range(0, 255);
               qty   = $urandom_range(0, 1) ? COIL_ON : 0;
            end
            default: begin
               start = $urandom_range(0, 127);
               qty   = $urandom_range(0, 65535);
            end
         endcase
         if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 2))
               0: start = $urandom_range(0, 65535);
               1: qty = $urandom_range(0, 65535);
               default: qty = 0;
            endcase
         end
         if (fn == FN_WRITE_COILS) bc = (qty + 7) / 8;
         if (fn == FN_WRITE_REGS) bc = qty * 2;
         if (bc > 100) bc = $urandom_range(0, 100);
         if (bc >= 0 && $urandom_range(0, 9) == 0) bc = (bc + 1) % 100;
         if (bc >= 0) nbytes = bc;
         request(adr, fn, 16'(start), 16'(qty), nbytes, bc);
         if (r < 20) frame_q[$urandom_range(0, frame_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
         else if (r < 24) repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end
      send_frame();
   endtask

   // let the block go quiet before a register write
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {CSR_SLAVE_ADDR, 2'b00};
      pwdata  <= {24'h0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_station = v;
   endtask

   task automatic run_random(input int target);
      while (words_sent < target) begin
         if ($urandom_range(0, 9) < 3) host_word();
         else random_frame();
      end
   endtask

   initial begin
      logic [7:0] settings[4];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      calm        = 1'b0;
      idle_cycles = 0;
      words_sent  = 0;
      cur_station = 8'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // host side at the index extremes
      send_word(CMD_READ_HREG, 8'h00, 1'b0, 8'd0, 16'h0000);
      send_word(CMD_READ_COIL, 8'hFF, 1'b1, 8'd255, 16'hFFFF);
      send_word(CMD_READ_HREG, 8'h00, 1'b0, 8'd200, 16'h0000);
      send_word(CMD_WRITE_IREG, 8'h00, 1'b0, 8'd0, 16'hFFFF);
      send_word(CMD_WRITE_IREG, 8'h00, 1'b0, 8'd255, 16'h1234);
      send_word(CMD_SET_IBIT, 8'h00, 1'b0, 8'd0, 16'h0001);
      send_word(CMD_SET_IBIT, 8'h00, 1'b0, 8'd255, 16'hFFFF);
      send_word(3'd7, 8'hFF, 1'b1, 8'hFF, 16'hFFFF);

      // every function, the bit masking and the read limits
      request(8'd1, FN_READ_INPUT, 0, 2, 0, -1);     send_frame();
      request(8'd1, FN_READ_DISCRETE, 0, 9, 0, -1);  send_frame();
      request(8'd1, FN_READ_DISCRETE, 247, 9, 0, -1); send_frame();
      request(8'd1, FN_WRITE_COIL, 255, COIL_ON, 0, -1); send_frame();
      request(8'd1, FN_READ_COILS, 248, 8, 0, -1);   send_frame();
      request(8'd1, FN_WRITE_REG, 127, 16'hABCD, 0, -1); send_frame();
      request(8'd1, FN_READ_HOLDING, 127, 1, 0, -1); send_frame();
      request(8'd1, FN_WRITE_COILS, 0, 10, 2, 2);    send_frame();
      request(8'd1, FN_WRITE_REGS, 0, 2, 4, 4);      send_frame();
      request(8'd1, FN_READ_HOLDING, 0, 29, 0, -1);  send_frame();
      // exceptions: counts, bounds, coil value, byte count, unknown function
      request(8'd1, FN_READ_HOLDING, 0, 30, 0, -1);  send_frame();
      request(8'd1, FN_READ_HOLDING, 0, 0, 0, -1);   send_frame();
      request(8'd1, FN_READ_HOLDING, 128, 1, 0, -1); send_frame();
      request(8'd1, FN_READ_HOLDING, 120, 9, 0, -1); send_frame();
      request(8'd1, FN_WRITE_COIL, 3, 16'h1234, 0, -1); send_frame();
      request(8'd1, FN_WRITE_COILS, 0, 10, 1, 1);    send_frame();
      request(8'd1, 8'h07, 0, 1, 0, -1);             send_frame();
      // broadcast, other station, bad CRC, short frame
      request(BROADCAST_ADDR, FN_READ_HOLDING, 0, 3, 0, -1); send_frame();
      request(8'd9, FN_WRITE_REG, 5, 16'h5555, 0, -1); send_frame();
      request(8'd1, FN_WRITE_REG, 6, 16'h6666, 0, -1);
      frame_q[7] ^= 8'h01;
      send_frame();
      frame_q.delete();
      frame_q.push_back(8'd1);
      frame_q.push_back(FN_READ_HOLDING);
      frame_q.push_back(8'h00);
      send_frame();

      run_random(100);
      settings[0] = 8'd0;
      settings[1] = 8'd255;
      settings[2] = 8'($urandom_range(2, 254));
      settings[3] = 8'd1;
      for (int p = 0; p < 4; p++) begin
         settle();
         write_station(settings[p]);
         calm = (p == 2);
         run_random(100 + 80 * (p + 1));
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("covered %0d request words under 5 station addresses", words_sent);
      $display("%0d response frames and %0d host reads checked", frames_answered, host_reads);
      if (fail_count == 0) begin
         $display("modbus_rtu_slave_responder_unit_tb OK");
      end else begin
         $display("modbus_rtu_slave_responder_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== modbus_rtu_slave_responder_unit.f =====
design/mbrs_pkg.sv
design/mbrs_regfile.sv
design/modbus_rtu_slave_responder_unit.sv
verif/modbus_rtu_slave_responder_unit_chk.sv
verif/modbus_rtu_slave_responder_unit_tb.sv
